// ===== sv/hmc_pkg.sv =====
package hmc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int SAMPLE_BITS      = 24;
    localparam int CHAN_W           = 8;
    localparam int QUOT_W           = 8;
    localparam logic [7:0] NB_RESET   = 8'd10;
    localparam logic [7:0] NB_MAX     = 8'd240;
    localparam logic [7:0] HUE_MAX    = 8'd240;
    localparam logic [7:0] STEP_RESET = 8'd24;
    localparam logic [7:0] CHAN_FULL  = 8'd255;
    localparam logic [7:0] SECTOR_DEG = 8'd60;

    typedef enum logic {
        KIND_SCAN = 1'b0,
        KIND_MAP  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic signed [SAMPLE_BITS-1:0]  sample;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [7:0]        bucket_index;
        logic [7:0]        hue_degrees;
        logic              blank_sample;
        logic              range_error;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_PREP,
        S_MUL,
        S_DIV,
        S_HUE,
        S_COLOR
    } t_state;

    // Rounded x*255/60 for x in 0..60, which equals floor((17*x + 2) / 4).
    function automatic logic [CHAN_W-1:0] ramp(input logic [7:0] x);
        logic [10:0] t;
        t = 11'(x) * 11'd17 + 11'd2;
        return t[9:2];
    endfunction

endpackage

// ===== sv/heat_map_colorizer.sv =====
// Heat map colorizer: quantized pseudocolor for a data set streamed twice.
// Input channel i_in_valid/o_in_ready carries one word of kind and sample.
// A scan word (kind scan) updates the running maximum and the smallest
// nonzero minimum in the cycle it is accepted and gives no result.
// A map word gives one result word on o_out_valid/i_out_ready: white for a
// zero sample, otherwise a bucket, its hue and the RGB color of that hue.
// A map word that needs the divider passes from acceptance to a valid
// result through two setup steps, the shared restoring divider (one
// quotient bit per cycle, then a done flag), one hue multiply and one
// color step. A blank word, an empty range or a sample at or beyond either
// end of the range skips the divider. Scan words can follow one per
// cycle; no new word is taken while a map word is in progress.
// A write to num_buckets through i_cfg_we/i_cfg_data takes effect at once and
// reuses the divider for 240/num_buckets, so the input is not ready until
// that division is done.
// Reset sets num_buckets to 10 and clears the running range.
// A finished result waits in the output register; while the receiver stalls,
// scan words are still accepted, and the next map result holds in its last
// step until the output register frees.
module heat_map_colorizer #(
    parameter int SAMPLE_WIDTH = hmc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hmc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hmc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int NW = SW + 9;
    localparam int PW = SW + 8;

    hmc_pkg::t_state r_state;
    hmc_pkg::t_state n_state;

    logic signed [SW-1:0] r_max;
    logic signed [SW-1:0] r_min;
    logic                 r_min_seen;
    logic [7:0]           r_nb;
    logic [7:0]           r_step;
    logic signed [SW-1:0] r_v;
    logic [SW-1:0]        r_diff;
    logic [SW-1:0]        r_den;
    logic                 r_blank;
    logic                 r_err;
    logic                 r_zb;
    logic                 r_sat;
    logic [7:0]           r_bucket;
    logic [7:0]           r_hue;
    hmc_pkg::t_out_item   r_out;
    logic                 r_out_valid;

    logic signed [SW-1:0] w_v;
    logic                 w_in_acc;
    logic                 w_in_ready;
    logic                 w_div_start;
    logic                 w_out_load;
    logic [7:0]           w_nb_clamp;
    logic [7:0]           w_nb1;
    logic [PW-1:0]        w_prod;
    logic [NW-1:0]        w_div_num;
    logic [NW-1:0]        w_div_den;
    logic                 w_div_done;
    logic [7:0]           w_quot;
    logic [15:0]          w_hue_prod;
    logic [7:0]           w_sec_m;
    logic [7:0]           w_red;
    logic [7:0]           w_green;
    logic [7:0]           w_blue;

    // Only the low SAMPLE_WIDTH bits of the field count, taken as signed.
    assign w_v      = SW'($unsigned(i_in_data.sample));
    assign w_in_acc = i_in_valid && w_in_ready;

    assign w_nb_clamp = (i_cfg_data == 8'd0) ? 8'd1 :
                        (i_cfg_data > hmc_pkg::NB_MAX) ? hmc_pkg::NB_MAX : i_cfg_data;
    assign w_nb1      = r_nb - 8'd1;
    assign w_prod     = PW'(r_diff) * PW'(w_nb1);

    // Step division is 240 / buckets; bucket division is (2*num + den) / (2*den).
    always_comb begin
        if (i_cfg_we) begin
            w_div_num = NW'(hmc_pkg::HUE_MAX);
            w_div_den = NW'(w_nb_clamp);
        end else begin
            w_div_num = NW'({w_prod, 1'b0}) + NW'(r_den);
            w_div_den = NW'({r_den, 1'b0});
        end
    end

    hmc_div #(
        .NW(NW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hmc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hmc_pkg::S_IDLE: begin
                if (i_cfg_we) begin
                    n_state = hmc_pkg::S_STEP;
                end else if (w_in_acc && i_in_data.kind == hmc_pkg::KIND_MAP) begin
                    n_state = hmc_pkg::S_PREP;
                end
            end
            hmc_pkg::S_STEP: begin
                if (!i_cfg_we && w_div_done) begin
                    n_state = hmc_pkg::S_IDLE;
                end
            end
            hmc_pkg::S_PREP: begin
                n_state = hmc_pkg::S_MUL;
            end
            hmc_pkg::S_MUL: begin
                n_state = (r_zb || r_sat) ? hmc_pkg::S_HUE : hmc_pkg::S_DIV;
            end
            hmc_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = hmc_pkg::S_HUE;
                end
            end
            hmc_pkg::S_HUE: begin
                n_state = hmc_pkg::S_COLOR;
            end
            hmc_pkg::S_COLOR: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = hmc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hmc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            hmc_pkg::S_IDLE: begin
                w_in_ready  = !i_cfg_we;
                w_div_start = i_cfg_we;
            end
            hmc_pkg::S_STEP: begin
                w_div_start = i_cfg_we;
            end
            hmc_pkg::S_MUL: begin
                w_div_start = !(r_zb || r_sat);
            end
            hmc_pkg::S_COLOR: begin
                w_out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= {1'b1, {(SW-1){1'b0}}};
            r_min      <= '0;
            r_min_seen <= 1'b0;
            r_nb       <= hmc_pkg::NB_RESET;
            r_step     <= hmc_pkg::STEP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_nb <= w_nb_clamp;
            end
            if (r_state == hmc_pkg::S_STEP && w_div_done && !i_cfg_we) begin
                r_step <= w_quot;
            end
            if (w_in_acc && i_in_data.kind == hmc_pkg::KIND_SCAN) begin
                if (w_v > r_max) begin
                    r_max <= w_v;
                end
                if (w_v != '0 && (!r_min_seen || w_v < r_min)) begin
                    r_min      <= w_v;
                    r_min_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_v <= w_v;
        end
        if (r_state == hmc_pkg::S_PREP) begin
            r_blank <= (r_v == '0);
            r_err   <= !r_min_seen || (r_max <= r_min);
            // A bucket of zero covers blank words, an empty range and samples
            // at or below the minimum; at or above the maximum it saturates.
            r_zb    <= (r_v == '0) || !r_min_seen || (r_max <= r_min) || (r_v <= r_min);
            r_sat   <= (r_v >= r_max);
            r_diff  <= SW'(r_v - r_min);
            r_den   <= SW'(r_max - r_min);
        end
        if (r_state == hmc_pkg::S_MUL) begin
            if (r_zb) begin
                r_bucket <= '0;
            end else if (r_sat) begin
                r_bucket <= w_nb1;
            end
        end
        if (r_state == hmc_pkg::S_DIV && w_div_done) begin
            r_bucket <= w_quot;
        end
        if (r_state == hmc_pkg::S_HUE) begin
            r_hue <= hmc_pkg::HUE_MAX - w_hue_prod[7:0];
        end
    end

    assign w_hue_prod = 16'(r_bucket) * 16'(r_step);

    // Hue to RGB with full saturation and value, one 60 degree sector at a time.
    always_comb begin
        w_sec_m = '0;
        w_red   = '0;
        w_green = '0;
        w_blue  = '0;
        if (r_hue < 8'd60) begin
            w_sec_m = r_hue;
            w_red   = hmc_pkg::CHAN_FULL;
            w_green = hmc_pkg::ramp(w_sec_m);
        end else if (r_hue < 8'd120) begin
            w_sec_m = r_hue - 8'd60;
            w_red   = hmc_pkg::ramp(hmc_pkg::SECTOR_DEG - w_sec_m);
            w_green = hmc_pkg::CHAN_FULL;
        end else if (r_hue < 8'd180) begin
            w_sec_m = r_hue - 8'd120;
            w_green = hmc_pkg::CHAN_FULL;
            w_blue  = hmc_pkg::ramp(w_sec_m);
        end else if (r_hue < 8'd240) begin
            w_sec_m = r_hue - 8'd180;
            w_green = hmc_pkg::ramp(hmc_pkg::SECTOR_DEG - w_sec_m);
            w_blue  = hmc_pkg::CHAN_FULL;
        end else if (r_hue < 8'd255 - 8'd14) begin
            w_sec_m = r_hue - 8'd240;
            w_red   = hmc_pkg::ramp(w_sec_m);
            w_blue  = hmc_pkg::CHAN_FULL;
        end else begin
            w_sec_m = r_hue - 8'd241;
            w_red   = hmc_pkg::CHAN_FULL;
            w_blue  = hmc_pkg::ramp(hmc_pkg::SECTOR_DEG - w_sec_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.range_error <= r_err;
            r_out.blank_sample <= r_blank;
            if (r_blank) begin
                r_out.red          <= hmc_pkg::CHAN_FULL;
                r_out.green        <= hmc_pkg::CHAN_FULL;
                r_out.blue         <= hmc_pkg::CHAN_FULL;
                r_out.bucket_index <= '0;
                r_out.hue_degrees  <= '0;
            end else begin
                r_out.red          <= w_red;
                r_out.green        <= w_green;
                r_out.blue         <= w_blue;
                r_out.bucket_index <= r_bucket;
                r_out.hue_degrees  <= r_hue;
            end
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_min_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_seen |-> (r_max >= r_min))
        else $error("running minimum above running maximum");

    a_blank_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.blank_sample) |->
        (o_out_data.red == 8'd255 && o_out_data.green == 8'd255 &&
         o_out_data.blue == 8'd255 && o_out_data.bucket_index == 8'd0))
        else $error("blank word not white");

    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.blank_sample) |-> (o_out_data.bucket_index < r_nb))
        else $error("bucket beyond bucket count");

    a_err_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error && !o_out_data.blank_sample) |->
        (o_out_data.bucket_index == 8'd0 && o_out_data.hue_degrees == hmc_pkg::HUE_MAX))
        else $error("empty range did not give bucket zero");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == hmc_pkg::S_STEP || r_state == hmc_pkg::S_DIV))
        else $error("divider finished with no waiting step");

endmodule

// ===== sv/hmc_div.sv =====
module hmc_div #(
    parameter int NW = hmc_pkg::SAMPLE_WIDTH_DEF + 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NW-1:0]             i_num,
    input  logic [NW-1:0]             i_den,
    output logic                      o_done,
    output logic [hmc_pkg::QUOT_W-1:0] o_quot
);

    localparam int QW = hmc_pkg::QUOT_W;
    localparam int CW = $clog2(QW);

    logic [NW-1:0] r_rem;
    logic [NW-1:0] r_dsh;
    logic [QW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          w_ge;

    // The quotient is known to fit in QW bits, so the divisor starts shifted
    // up by QW-1 and one quotient bit is settled per cycle.
    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= i_den << (QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
